// ===== hw/rtl/cdms_pkg.sv =====
`default_nettype none
package cdms_pkg;
   localparam int TimerBits = 32;
   localparam int SetBits = 10;
   localparam int HoldTicks = 64;
   localparam int StrikeWindow = 12;
   localparam int SwingMin = 50;

   localparam logic [1:0] EV_REST = 2'd0;
   localparam logic [1:0] EV_PASS = 2'd1;
   localparam logic [1:0] EV_GEN = 2'd2;

   localparam logic CSR_MODE_A = 1'b0;
   localparam logic CSR_MODE_B = 1'b1;

   typedef struct packed {
      logic          start;
      logic [TimerBits-1:0] num;
      logic [TimerBits-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [TimerBits-1:0] quo;
      logic [TimerBits-1:0] rem;
   } div_rsp_type;

   // signed factor index: -8..-2, 1, 2..8
   function automatic logic signed [4:0] factor_of(input logic [SetBits-1:0] s);
      logic signed [SetBits+5:0] x;
      logic [SetBits+5:0] mag;
      logic [SetBits+5:0] m;
      logic [SetBits+5:0] q;
      logic signed [4:0] idx;
      m = (SetBits+6)'((1 << SetBits) - 1);
      x = $signed((SetBits+6)'(14) * {6'd0, s}) - $signed((SetBits+6)'(7) * m);
      mag = x[SetBits+5] ? (SetBits+6)'(-x) : (SetBits+6)'(x);
      q = '0;
      for (int k = 1; k <= 7; k++) begin
         if (mag * 2 >= m * (SetBits+6)'(2*k-1)) q = (SetBits+6)'(k);
      end
      idx = x[SetBits+5] ? -$signed(5'(q)) : $signed(5'(q));
      if (idx == 0) factor_of = 5'sd1;
      else if (idx < 0) factor_of = idx - 5'sd1;
      else factor_of = idx + 5'sd1;
   endfunction

   // swing percent 50..70
   function automatic logic [6:0] swing_of(input logic [SetBits-1:0] s);
      logic [SetBits+5:0] p;
      logic [SetBits+5:0] m;
      logic [6:0] q;
      m = (SetBits+6)'((1 << SetBits) - 1);
      p = (SetBits+6)'(20) * {6'd0, s};
      q = '0;
      for (int k = 1; k <= 20; k++) begin
         if (p >= m * (SetBits+6)'(k)) q = 7'(k);
      end
      swing_of = 7'(SwingMin) + q;
   endfunction

   // floor(1000 / swing) for swing 51..70 is 19 down to 14
   function automatic logic [4:0] swing_den(input logic [6:0] sw);
      swing_den = 5'd20;
      for (int k = 14; k <= 20; k++) begin
         if (32'(sw) * 32'(k) <= 32'd1000) swing_den = 5'(k);
      end
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/cdms_div.sv =====
`default_nettype none
module cdms_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cdms_pkg::div_req_type req,
   output cdms_pkg::div_rsp_type     rsp
);
   localparam int W = cdms_pkg::TimerBits;
   logic [W-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [$clog2(W+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in = req.num; rem_in = '0; den_in = req.den;
         cnt_in = ($clog2(W+1))'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
   assign rsp.rem = rem_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/clock_divide_multiply_swing.sv =====
// channel | dir | fields (low bit up)
// req     | in  | tdata: setting_a[9:0] setting_b[19:10]; tuser: clock reset btn_a btn_b
// rsp     | out | tdata: event_a[1:0] event_b[3:2]; tuser: gate_a gate_b
// csr     | in  | index 1 bit (0 mode_a, 1 mode_b), data bit 0
// Each factorer or swing section that needs it runs up to two passes of a shared
// 32-bit radix-2 divider.
// Synchronous reset clears state except per-beat registers; modes return to mode_a 1, mode_b 0.
// A result waits in an output register while the next beat is taken; the sequencer
// holds before loading its own result until the waiting one has gone.
`default_nettype none
module clock_divide_multiply_swing (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // setting_a, setting_b, zero fill
   input  wire logic [3:0]  req_tuser,   // clock_level, reset_level, button_reset_a, button_reset_b
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // event_a, event_b, zero fill
   output logic [1:0]       rsp_tuser,   // gate_a, gate_b
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int W = cdms_pkg::TimerBits;
   localparam int S = cdms_pkg::SetBits;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PREP = 7'b0000010,
      ST_DIV1 = 7'b0000100,
      ST_DIV2 = 7'b0001000,
      ST_FIN  = 7'b0010000,
      ST_NEXT = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [W-1:0] timer_ff, timer_in, et0_ff, et0_in, et1_ff, et1_in;
   logic [1:0] seen_ff, seen_in;
   logic [3:0] prev_ff, prev_in;
   logic [2:0] dcnt_ff [2], dcnt_in [2];
   logic [4:0] pl_ff [2], pl_in [2];
   logic [1:0] deb_ff, deb_in;
   logic [1:0] sstep_ff [2], sstep_in [2];
   logic [6:0] hold_ff [2], hold_in [2];
   logic [1:0] ev_ff [2], ev_in [2];
   logic [1:0] gate_ff, gate_in;
   logic sec_ff, sec_in, trig_ff, trig_in, rste_ff, rste_in;
   logic [1:0] btne_ff, btne_in;
   logic [S-1:0] set_ff [2], set_in [2];
   logic [W-1:0] iv_ff, iv_in;
   logic [W+5:0] p20;
   logic rsp_v_ff, rsp_v_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;
   cdms_pkg::div_req_type dreq;
   cdms_pkg::div_rsp_type drsp;

   cdms_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [W-1:0] elapsed, period;
   logic signed [4:0] fac;
   logic [3:0] af;
   logic [6:0] sw;
   logic md;
   logic [1:0] ev;
   logic [2:0] dc;
   logic [1:0] ss;
   logic [W+5:0] siv;

   assign elapsed = timer_ff - et1_ff;
   assign period = et1_ff - et0_ff;
   assign md = mode_ff[sec_ff];
   assign fac = cdms_pkg::factor_of(set_ff[sec_ff]);
   assign af = fac[4] ? 4'(-fac) : 4'(fac);
   assign sw = cdms_pkg::swing_of(set_ff[sec_ff]);
   assign p20 = (W+6)'(period) * (W+6)'(20);

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; timer_in = timer_ff;
      et0_in = et0_ff; et1_in = et1_ff; seen_in = seen_ff; prev_in = prev_ff;
      dcnt_in = dcnt_ff; pl_in = pl_ff; deb_in = deb_ff; sstep_in = sstep_ff;
      hold_in = hold_ff; ev_in = ev_ff; gate_in = gate_ff; sec_in = sec_ff;
      trig_in = trig_ff; rste_in = rste_ff; btne_in = btne_ff; set_in = set_ff;
      iv_in = iv_ff; rsp_v_in = rsp_v_ff;
      rsp_data_in = rsp_data_ff; rsp_user_in = rsp_user_ff;
      dreq.start = 1'b0; dreq.num = '0; dreq.den = '0;
      ev = cdms_pkg::EV_REST; dc = dcnt_ff[sec_ff]; ss = sstep_ff[sec_ff];
      siv = '0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cdms_pkg::CSR_MODE_A: mode_in[0] = csr_data[0];
            cdms_pkg::CSR_MODE_B: mode_in[1] = csr_data[0];
            default: ;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) begin
            btne_in = req_tuser[3:2] & ~prev_ff[3:2];
            timer_in = timer_ff + 1'b1;
            trig_in = req_tuser[0] & ~prev_ff[0];
            rste_in = req_tuser[1] & ~prev_ff[1];
            prev_in = req_tuser;
            if (req_tuser[0] && !prev_ff[0]) begin
               et0_in = et1_ff; et1_in = timer_ff + 1'b1;
               if (seen_ff != 2'd2) seen_in = seen_ff + 1'b1;
            end
            set_in[0] = req_tdata[S-1:0];
            set_in[1] = req_tdata[2*S-1:S];
            sec_in = 1'b0;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // button reset, then event from beat, then reset input
            if (btne_ff[sec_ff]) begin
               if (md) ss = '0; else dc = '0;
            end
            if (!md) begin
               if (trig_ff) begin
                  if (fac > 5'sd1) begin
                     if (dc == 0) ev = cdms_pkg::EV_GEN;
                     if ($signed({2'b00, dc}) >= fac - 5'sd1) dc = '0;
                     else dc = dc + 1'b1;
                  end else begin
                     ev = cdms_pkg::EV_PASS; pl_in[sec_ff] = '0;
                  end
               end
               if (rste_ff) dc = '0;
            end else begin
               if (trig_ff) begin
                  if (ss == 0) begin
                     ev = cdms_pkg::EV_PASS; ss = 2'd1;
                  end else if (ss == 1) begin
                     if (sw <= 7'(cdms_pkg::SwingMin)) begin
                        ev = cdms_pkg::EV_GEN; ss = '0;
                     end else ss = 2'd2;
                  end else ss = '0;
               end
               if (rste_ff) ss = '0;
            end
            dcnt_in[sec_ff] = dc; sstep_in[sec_ff] = ss; ev_in[sec_ff] = ev;
            if (!md && fac < 5'sd1 && seen_ff == 2'd2) begin
               dreq.start = 1'b1; dreq.num = period; dreq.den = W'(af);
               state_in = ST_DIV1;
            end else if (md && ss >= 2'd2 && sw > 7'(cdms_pkg::SwingMin)) begin
               dreq.start = 1'b1; dreq.num = W'(p20 >> 5);
               dreq.den = W'(cdms_pkg::swing_den(sw));
               state_in = ST_DIV1;
            end else state_in = ST_FIN;
         end
         ST_DIV1: if (drsp.done) begin
            if (!md) begin
               iv_in = drsp.quo;
               if (drsp.quo == 0) begin
                  deb_in[sec_ff] = 1'b0; state_in = ST_FIN;
               end else begin
                  dreq.start = 1'b1; dreq.num = elapsed; dreq.den = drsp.quo;
                  state_in = ST_DIV2;
               end
            end else begin
               // 20p/d built from (20p>>5)/d: finish with the low five bits
               dreq.start = 1'b1;
               dreq.num = {drsp.rem[W-6:0], p20[4:0]};
               dreq.den = W'(cdms_pkg::swing_den(sw));
               iv_in = drsp.quo;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: if (drsp.done) begin
            if (!md) begin
               if (drsp.rem <= W'(cdms_pkg::StrikeWindow)) begin
                  if (!deb_ff[sec_ff] && pl_ff[sec_ff] <= 5'(af)) begin
                     ev_in[sec_ff] = cdms_pkg::EV_GEN; deb_in[sec_ff] = 1'b1;
                     if (pl_ff[sec_ff] < 5'd31) pl_in[sec_ff] = pl_ff[sec_ff] + 1'b1;
                  end
               end else deb_in[sec_ff] = 1'b0;
            end else begin
               siv = {iv_ff[W-1:0], 5'd0} + (W+6)'(drsp.quo) - (W+6)'(period);
               if ((W+6)'(elapsed) >= siv &&
                   (W+6)'(elapsed) <= siv + (W+6)'(cdms_pkg::StrikeWindow)) begin
                  ev_in[sec_ff] = cdms_pkg::EV_GEN; sstep_in[sec_ff] = '0;
               end
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (ev_ff[sec_ff] != cdms_pkg::EV_REST) begin
               gate_in[sec_ff] = 1'b1; hold_in[sec_ff] = 7'(cdms_pkg::HoldTicks);
            end else if (hold_ff[sec_ff] == 0) gate_in[sec_ff] = 1'b0;
            else begin
               gate_in[sec_ff] = 1'b1; hold_in[sec_ff] = hold_ff[sec_ff] - 1'b1;
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (sec_ff) state_in = ST_OUT;
            else begin
               sec_in = 1'b1; state_in = ST_PREP;
            end
         end
         ST_OUT: if (!rsp_v_ff || rsp_tready) begin
            rsp_v_in = 1'b1; state_in = ST_IDLE;
            rsp_data_in = {4'd0, ev_ff[1], ev_ff[0]};
            rsp_user_in = gate_ff;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; mode_ff <= 2'b01; timer_ff <= '0;
         et0_ff <= '0; et1_ff <= '0; seen_ff <= '0; prev_ff <= '0;
         deb_ff <= '0; gate_ff <= '0; rsp_v_ff <= 1'b0;
         rsp_data_ff <= '0; rsp_user_ff <= '0;
         for (int i = 0; i < 2; i++) begin
            dcnt_ff[i] <= '0; pl_ff[i] <= '0; sstep_ff[i] <= '0;
            hold_ff[i] <= '0; ev_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; mode_ff <= mode_in; timer_ff <= timer_in;
         et0_ff <= et0_in; et1_ff <= et1_in; seen_ff <= seen_in; prev_ff <= prev_in;
         deb_ff <= deb_in; gate_ff <= gate_in; rsp_v_ff <= rsp_v_in;
         rsp_data_ff <= rsp_data_in; rsp_user_ff <= rsp_user_in;
         dcnt_ff <= dcnt_in; pl_ff <= pl_in; sstep_ff <= sstep_in;
         hold_ff <= hold_in; ev_ff <= ev_in;
      end
      sec_ff <= sec_in; trig_ff <= trig_in; rste_ff <= rste_in; btne_ff <= btne_in;
      set_ff <= set_in; iv_ff <= iv_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/cdms_check.sv =====
`default_nettype none
module cdms_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed");
   a_ev_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3) else $error("bad event_a");
   a_gate_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tuser[0]) else $error("gate_a low");
   a_gate_b: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:2] != 2'd0 |-> rsp_tuser[1]) else $error("gate_b low");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready during work");
endmodule

bind clock_divide_multiply_swing cdms_check u_check (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire
